// ===== rtl/lrci_pkg.sv =====
// Shared constants, codes and types of the line rasteriser with colour interpolation.
`timescale 1ns / 1ps
`default_nettype none

package lrci_pkg;

   localparam int COORD_BITS   = 14;
   localparam int SPAN_BITS    = COORD_BITS + 1;
   localparam int ERR_BITS     = COORD_BITS + 2;
   localparam int E2_BITS      = COORD_BITS + 3;
   localparam int DIM_BITS     = 13;
   localparam int CMP_BITS     = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
   localparam int CHAN_BITS    = 8;
   localparam int NUM_LANES    = 3;
   localparam int LANE_RED     = 0;
   localparam int LANE_GREEN   = 1;
   localparam int LANE_BLUE    = 2;
   localparam int DIV_CNT_BITS = $clog2(CHAN_BITS);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(768);

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [NUM_LANES-1:0][CHAN_BITS-1:0] lanes_type;
   typedef logic [NUM_LANES-1:0][SPAN_BITS-1:0] rems_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [COORD_BITS-1:0]  x0;
      logic [COORD_BITS-1:0]  y0;
      logic [COORD_BITS-1:0]  x1;
      logic [COORD_BITS-1:0]  y1;
      logic [SPAN_BITS-1:0]   span_x;
      logic [SPAN_BITS-1:0]   span_y;
      logic                   dir_x_neg;
      logic                   dir_y_neg;
      lanes_type              color_first;
      lanes_type              color_delta;
      logic [NUM_LANES-1:0]   color_down;
   } entry_type;

   typedef struct packed {
      logic                 start;
      logic [SPAN_BITS-1:0] divisor;
      lanes_type            dividend;
   } div_req_type;

   typedef struct packed {
      logic      done;
      lanes_type quotient;
      rems_type  remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/lrci_front.sv =====
// Front end: accepts requests and works out spans, directions and colour deltas.
`timescale 1ns / 1ps
`default_nettype none

module lrci_front import lrci_pkg::*; (
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_command,
   input  wire logic [COORD_BITS-1:0] req_x_start,
   input  wire logic [COORD_BITS-1:0] req_y_start,
   input  wire logic [COORD_BITS-1:0] req_x_end,
   input  wire logic [COORD_BITS-1:0] req_y_end,
   input  wire lanes_type             color_start,
   input  wire lanes_type             color_end,
   input  wire logic                  queue_full,
   output logic                       push,
   output entry_type                  entry
);

   logic signed [SPAN_BITS-1:0] diff_x;
   logic signed [SPAN_BITS-1:0] diff_y;

   always_comb begin
      diff_x = signed'({req_x_end[COORD_BITS-1], req_x_end})
             - signed'({req_x_start[COORD_BITS-1], req_x_start});
      diff_y = signed'({req_y_end[COORD_BITS-1], req_y_end})
             - signed'({req_y_start[COORD_BITS-1], req_y_start});

      entry.cmd       = cmd_type'(req_command);
      entry.x0        = req_x_start;
      entry.y0        = req_y_start;
      entry.x1        = req_x_end;
      entry.y1        = req_y_end;
      entry.span_x    = diff_x[SPAN_BITS-1] ? SPAN_BITS'(-diff_x) : SPAN_BITS'(diff_x);
      entry.span_y    = diff_y[SPAN_BITS-1] ? SPAN_BITS'(-diff_y) : SPAN_BITS'(diff_y);
      // The walk steps negative unless the end lies strictly beyond the start.
      entry.dir_x_neg = diff_x[SPAN_BITS-1] || (diff_x == '0);
      entry.dir_y_neg = diff_y[SPAN_BITS-1] || (diff_y == '0);
      entry.color_first = color_start;
      for (int l = 0; l < NUM_LANES; l++) begin
         entry.color_down[l]  = color_end[l] < color_start[l];
         entry.color_delta[l] = entry.color_down[l] ? color_start[l] - color_end[l]
                                                    : color_end[l] - color_start[l];
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

`default_nettype wire

// ===== rtl/lrci_queue.sv =====
// Two-entry queue between the front end and the line walker.
`timescale 1ns / 1ps
`default_nettype none

module lrci_queue import lrci_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head_entry
);

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/lrci_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle, for the colour step setup.
`timescale 1ns / 1ps
`default_nettype none

module lrci_div import lrci_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [SPAN_BITS-1:0]    divisor_ff, divisor_in;
   lanes_type               dvd_ff, dvd_in;
   lanes_type               quo_ff, quo_in;
   rems_type                rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [SPAN_BITS:0]      trial [NUM_LANES];
   logic [NUM_LANES-1:0]    fits;

   always_comb begin
      divisor_in = divisor_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
         trial[l] = {rem_ff[l], dvd_ff[l][CHAN_BITS-1]};
         fits[l]  = trial[l] >= {1'b0, divisor_ff};
      end
      if (req.start) begin
         divisor_in = req.divisor;
         dvd_in     = req.dividend;
         quo_in     = '0;
         rem_in     = '0;
         cnt_in     = '0;
         run_in     = 1'b1;
      end else if (run_ff) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            rem_in[l] = fits[l] ? SPAN_BITS'(trial[l] - {1'b0, divisor_ff})
                                : trial[l][SPAN_BITS-1:0];
            quo_in[l] = {quo_ff[l][CHAN_BITS-2:0], fits[l]};
            dvd_in[l] = {dvd_ff[l][CHAN_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(CHAN_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      divisor_ff <= divisor_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/lrci_back.sv =====
// Back end: Bresenham walker with incremental colour accumulators and output register.
`timescale 1ns / 1ps
`default_nettype none

module lrci_back import lrci_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire entry_type             head_entry,
   output logic                       pop,
   input  wire logic [DIM_BITS-1:0]   image_width,
   input  wire logic [DIM_BITS-1:0]   image_height,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_pixel_x,
   output logic [COORD_BITS-1:0]      rsp_pixel_y,
   output lanes_type                  rsp_color,
   output logic                       rsp_in_image,
   output logic                       rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_WALK
   } state_type;

   state_type                   state_ff, state_in;
   logic [COORD_BITS-1:0]       cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]       cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]       tgt_x_ff, tgt_x_in;
   logic [COORD_BITS-1:0]       tgt_y_ff, tgt_y_in;
   logic [SPAN_BITS-1:0]        span_x_ff, span_x_in;
   logic [SPAN_BITS-1:0]        span_y_ff, span_y_in;
   logic                        dir_x_ff, dir_x_in;
   logic                        dir_y_ff, dir_y_in;
   logic signed [ERR_BITS-1:0]  err_ff, err_in;
   logic [SPAN_BITS-1:0]        total_ff, total_in;
   lanes_type                   base_ff, base_in;
   logic [NUM_LANES-1:0]        down_ff, down_in;
   lanes_type                   acc_q_ff, acc_q_in;
   rems_type                    acc_r_ff, acc_r_in;
   lanes_type                   step_q_ff, step_q_in;
   rems_type                    step_r_ff, step_r_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]       rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]       rsp_y_ff, rsp_y_in;
   lanes_type                   rsp_color_ff, rsp_color_in;
   logic                        rsp_inside_ff, rsp_inside_in;
   logic                        rsp_last_ff, rsp_last_in;

   div_req_type                 div_req;
   div_rsp_type                 div_rsp;

   logic                        out_free;
   logic                        do_load;
   logic                        do_emit;
   logic [SPAN_BITS-1:0]        total_load;
   logic                        pix_inside;
   logic                        at_end;
   lanes_type                   pix_color;
   logic signed [E2_BITS-1:0]   e2;
   logic signed [E2_BITS-1:0]   sx_e;
   logic signed [E2_BITS-1:0]   sy_e;
   logic                        step_x;
   logic                        step_y;
   logic [SPAN_BITS:0]          rsum [NUM_LANES];
   logic [NUM_LANES-1:0]        carry;

   lrci_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      total_load = (head_entry.span_x > head_entry.span_y) ? head_entry.span_x
                                                           : head_entry.span_y;
      pix_inside = !cur_x_ff[COORD_BITS-1] && !cur_y_ff[COORD_BITS-1]
                && (CMP_BITS'(cur_x_ff) < CMP_BITS'(image_width))
                && (CMP_BITS'(cur_y_ff) < CMP_BITS'(image_height));
      at_end = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);

      // Colour is the start value plus or minus the running floor or ceiling of delta*n/steps.
      for (int l = 0; l < NUM_LANES; l++) begin
         pix_color[l] = down_ff[l]
                      ? base_ff[l] - acc_q_ff[l] - CHAN_BITS'(acc_r_ff[l] != '0)
                      : base_ff[l] + acc_q_ff[l];
         rsum[l]  = {1'b0, acc_r_ff[l]} + {1'b0, step_r_ff[l]};
         carry[l] = rsum[l] >= {1'b0, total_ff};
      end

      e2     = signed'({err_ff, 1'b0});
      sx_e   = signed'(E2_BITS'(span_x_ff));
      sy_e   = signed'(E2_BITS'(span_y_ff));
      step_x = e2 > -sy_e;
      step_y = e2 < sx_e;

      state_in      = state_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      tgt_x_in      = tgt_x_ff;
      tgt_y_in      = tgt_y_ff;
      span_x_in     = span_x_ff;
      span_y_in     = span_y_ff;
      dir_x_in      = dir_x_ff;
      dir_y_in      = dir_y_ff;
      err_in        = err_ff;
      total_in      = total_ff;
      base_in       = base_ff;
      down_in       = down_ff;
      acc_q_in      = acc_q_ff;
      acc_r_in      = acc_r_ff;
      step_q_in     = step_q_ff;
      step_r_in     = step_r_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_last_in   = rsp_last_ff;

      pop              = 1'b0;
      do_load          = 1'b0;
      do_emit          = 1'b0;
      div_req.start    = 1'b0;
      div_req.divisor  = total_load;
      div_req.dividend = head_entry.color_delta;

      unique case (state_ff)
         S_IDLE: begin
            // A tick with no line in progress is dropped.
            if (head_valid) begin
               pop     = 1'b1;
               do_load = (head_entry.cmd == CMD_START);
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               step_q_in = div_rsp.quotient;
               step_r_in = div_rsp.remainder;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (head_valid) begin
               if (head_entry.cmd == CMD_START) begin
                  pop     = 1'b1;
                  do_load = 1'b1;
               end else if (out_free) begin
                  pop     = 1'b1;
                  do_emit = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (do_load) begin
         cur_x_in  = head_entry.x0;
         cur_y_in  = head_entry.y0;
         tgt_x_in  = head_entry.x1;
         tgt_y_in  = head_entry.y1;
         span_x_in = head_entry.span_x;
         span_y_in = head_entry.span_y;
         dir_x_in  = head_entry.dir_x_neg;
         dir_y_in  = head_entry.dir_y_neg;
         err_in    = signed'(ERR_BITS'(head_entry.span_x))
                   - signed'(ERR_BITS'(head_entry.span_y));
         total_in  = total_load;
         base_in   = head_entry.color_first;
         down_in   = head_entry.color_down;
         acc_q_in  = '0;
         acc_r_in  = '0;
         step_q_in = '0;
         step_r_in = '0;
         // A line of zero length never steps, so the colour steps are not needed.
         if (total_load == '0) begin
            state_in = S_WALK;
         end else begin
            div_req.start = 1'b1;
            state_in      = S_DIV;
         end
      end

      if (do_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_x_in      = cur_x_ff;
         rsp_y_in      = cur_y_ff;
         rsp_color_in  = pix_color;
         rsp_inside_in = pix_inside;
         rsp_last_in   = at_end;
         if (at_end) begin
            state_in = S_IDLE;
         end else begin
            if (step_x) begin
               cur_x_in = dir_x_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
            end
            if (step_y) begin
               cur_y_in = dir_y_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
            end
            err_in = err_ff
                   - (step_x ? signed'(ERR_BITS'(span_y_ff)) : signed'(ERR_BITS'(0)))
                   + (step_y ? signed'(ERR_BITS'(span_x_ff)) : signed'(ERR_BITS'(0)));
            for (int l = 0; l < NUM_LANES; l++) begin
               acc_r_in[l] = carry[l] ? SPAN_BITS'(rsum[l] - {1'b0, total_ff})
                                      : rsum[l][SPAN_BITS-1:0];
               acc_q_in[l] = acc_q_ff[l] + step_q_ff[l] + CHAN_BITS'(carry[l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      tgt_x_ff      <= tgt_x_in;
      tgt_y_ff      <= tgt_y_in;
      span_x_ff     <= span_x_in;
      span_y_ff     <= span_y_in;
      dir_x_ff      <= dir_x_in;
      dir_y_ff      <= dir_y_in;
      err_ff        <= err_in;
      total_ff      <= total_in;
      base_ff       <= base_in;
      down_ff       <= down_in;
      acc_q_ff      <= acc_q_in;
      acc_r_ff      <= acc_r_in;
      step_q_ff     <= step_q_in;
      step_r_ff     <= step_r_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel_x  = rsp_x_ff;
   assign rsp_pixel_y  = rsp_y_ff;
   assign rsp_color    = rsp_color_ff;
   assign rsp_in_image = rsp_inside_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/line_raster_color_interp.sv =====
// Top level of the line rasteriser: configuration registers, front end, queue and walker.
`timescale 1ns / 1ps
`default_nettype none

// A start transfer (command 0) loads two signed endpoints and two RGB colours and gives no
// pixel; each following tick transfer (command 1) gives one pixel of the line, with its
// colour blended linearly between the endpoint colours (rounded down) and flags for lying
// inside the configured image and for being the end point. Ticks with no line in progress
// give nothing, and a start abandons any line still running. Requests pass through a
// two-entry queue, so a request is taken even while a pixel waits at the output, if the
// queue has room. A line being walked gives one pixel per clock cycle while ticks arrive and
// the output is free. A nonzero-length line goes through the bit-serial colour step divider
// once dequeued, before its first pixel; a zero-length line skips it and is ready at once.
// The image width and height registers should only be written while no line is in flight.
module line_raster_color_interp import lrci_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_command,
   input  wire logic signed [COORD_BITS-1:0] req_x_start,
   input  wire logic signed [COORD_BITS-1:0] req_y_start,
   input  wire logic signed [COORD_BITS-1:0] req_x_end,
   input  wire logic signed [COORD_BITS-1:0] req_y_end,
   input  wire logic [CHAN_BITS-1:0]      req_red_start,
   input  wire logic [CHAN_BITS-1:0]      req_green_start,
   input  wire logic [CHAN_BITS-1:0]      req_blue_start,
   input  wire logic [CHAN_BITS-1:0]      req_red_end,
   input  wire logic [CHAN_BITS-1:0]      req_green_end,
   input  wire logic [CHAN_BITS-1:0]      req_blue_end,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [COORD_BITS-1:0]   rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]   rsp_pixel_y,
   output logic [CHAN_BITS-1:0]           rsp_red,
   output logic [CHAN_BITS-1:0]           rsp_green,
   output logic [CHAN_BITS-1:0]           rsp_blue,
   output logic                           rsp_in_image,
   output logic                           rsp_last,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [DIM_BITS-1:0]       csr_data
);

   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   lanes_type             color_start;
   lanes_type             color_end;
   lanes_type             out_color;
   entry_type             push_entry;
   entry_type             head_entry;
   logic                  push;
   logic                  full;
   logic                  pop;
   logic                  head_valid;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_in  = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_ready = 1'b1;

   assign color_start[LANE_RED]   = req_red_start;
   assign color_start[LANE_GREEN] = req_green_start;
   assign color_start[LANE_BLUE]  = req_blue_start;
   assign color_end[LANE_RED]     = req_red_end;
   assign color_end[LANE_GREEN]   = req_green_end;
   assign color_end[LANE_BLUE]    = req_blue_end;

   lrci_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_x_start (unsigned'(req_x_start)),
      .req_y_start (unsigned'(req_y_start)),
      .req_x_end   (unsigned'(req_x_end)),
      .req_y_end   (unsigned'(req_y_end)),
      .color_start (color_start),
      .color_end   (color_end),
      .queue_full  (full),
      .push        (push),
      .entry       (push_entry)
   );

   lrci_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   lrci_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_entry   (head_entry),
      .pop          (pop),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_x  (out_x),
      .rsp_pixel_y  (out_y),
      .rsp_color    (out_color),
      .rsp_in_image (rsp_in_image),
      .rsp_last     (rsp_last)
   );

   assign rsp_pixel_x = signed'(out_x);
   assign rsp_pixel_y = signed'(out_y);
   assign rsp_red     = out_color[LANE_RED];
   assign rsp_green   = out_color[LANE_GREEN];
   assign rsp_blue    = out_color[LANE_BLUE];

endmodule

`default_nettype wire

// ===== rtl/lrci_checker.sv =====
// Port-level assertions for the line rasteriser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lrci_checker import lrci_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_pixel_x,
   input wire logic [COORD_BITS-1:0] rsp_pixel_y,
   input wire logic [CHAN_BITS-1:0]  rsp_red,
   input wire logic [CHAN_BITS-1:0]  rsp_green,
   input wire logic [CHAN_BITS-1:0]  rsp_blue,
   input wire logic                  rsp_in_image,
   input wire logic                  rsp_last
);

   // A pixel waiting at the output holds until it is transferred.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid
            && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_red)
            && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_in_image)
            && $stable(rsp_last);
   endproperty

   // Reset empties the output register.
   property p_reset_clears;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty

   // A pixel flagged inside the image cannot have a negative coordinate.
   property p_inside_nonneg;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_in_image |-> !rsp_pixel_x[COORD_BITS-1] && !rsp_pixel_y[COORD_BITS-1];
   endproperty

   a_rsp_hold:      assert property (p_rsp_hold)      else $error("pixel changed while stalled");
   a_reset_clears:  assert property (p_reset_clears)  else $error("pixel valid after reset");
   a_inside_nonneg: assert property (p_inside_nonneg) else $error("negative pixel flagged inside");

endmodule

bind line_raster_color_interp lrci_checker u_lrci_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_pixel_x  (rsp_pixel_x),
   .rsp_pixel_y  (rsp_pixel_y),
   .rsp_red      (rsp_red),
   .rsp_green    (rsp_green),
   .rsp_blue     (rsp_blue),
   .rsp_in_image (rsp_in_image),
   .rsp_last     (rsp_last)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the line rasteriser: predicts each pixel of every line and checks the block.
`timescale 1ns / 1ps

module tb;
   import lrci_pkg::*;

   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE    = 40;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [CHAN_BITS-1:0]         red;
      logic [CHAN_BITS-1:0]         green;
      logic [CHAN_BITS-1:0]         blue;
      logic                         in_image;
      logic                         last;
   } pixel_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   cmd_type                      req_command;
   logic signed [COORD_BITS-1:0] req_x_start, req_y_start, req_x_end, req_y_end;
   logic [CHAN_BITS-1:0]         req_red_start, req_green_start, req_blue_start;
   logic [CHAN_BITS-1:0]         req_red_end, req_green_end, req_blue_end;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [COORD_BITS-1:0] rsp_pixel_x, rsp_pixel_y;
   logic [CHAN_BITS-1:0]         rsp_red, rsp_green, rsp_blue;
   logic                         rsp_in_image;
   logic                         rsp_last;
   logic                         csr_valid;
   logic                         csr_ready;
   csr_index_type                csr_index;
   logic [DIM_BITS-1:0]          csr_data;

   // Copy of the walker state, kept in step with every accepted transfer.
   logic [DIM_BITS-1:0]          width_cfg  = WIDTH_RESET;
   logic [DIM_BITS-1:0]          height_cfg = HEIGHT_RESET;
   bit                           line_busy  = 1'b0;
   logic signed [COORD_BITS-1:0] walk_x = '0, walk_y = '0, goal_x = '0, goal_y = '0;
   int                           span_x_c = 0, span_y_c = 0, walk_err = 0;
   int                           pix_index = 0, pix_total = 0;
   bit                           x_neg = 1'b0, y_neg = 1'b0;
   logic [CHAN_BITS-1:0]         shade_from [NUM_LANES];
   logic [CHAN_BITS-1:0]         shade_to [NUM_LANES];
   pixel_type                    pixel_q [$];

   int err_count     = 0;
   int sent_items    = 0;
   bit idle_on       = 1'b1;
   bit hold_rsp_long = 1'b0;

   line_raster_color_interp u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_red_start   (req_red_start),
      .req_green_start (req_green_start),
      .req_blue_start  (req_blue_start),
      .req_red_end     (req_red_end),
      .req_green_end   (req_green_end),
      .req_blue_end    (req_blue_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_in_image    (rsp_in_image),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [CHAN_BITS-1:0] blend_channel(input int a, input int b,
                                                          input int n, input int steps);
      int num;
      if (steps == 0) return CHAN_BITS'(a);
      if (b >= a) num = a * steps + (b - a) * n;
      else num = a * steps - (a - b) * n;
      return CHAN_BITS'(num / steps);
   endfunction

   function automatic void load_line(input logic signed [COORD_BITS-1:0] x0, y0, x1, y1,
                                     input logic [CHAN_BITS-1:0] r0, g0, b0, r1, g1, b1);
      walk_x = x0;
      walk_y = y0;
      goal_x = x1;
      goal_y = y1;
      span_x_c = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
      span_y_c = (y1 >= y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
      x_neg = !(x0 < x1);
      y_neg = !(y0 < y1);
      walk_err = span_x_c - span_y_c;
      pix_index = 0;
      pix_total = (span_x_c > span_y_c) ? span_x_c : span_y_c;
      shade_from[LANE_RED]   = r0;
      shade_from[LANE_GREEN] = g0;
      shade_from[LANE_BLUE]  = b0;
      shade_to[LANE_RED]     = r1;
      shade_to[LANE_GREEN]   = g1;
      shade_to[LANE_BLUE]    = b1;
      line_busy = 1'b1;
   endfunction

   function automatic pixel_type next_pixel();
      pixel_type px;
      int        e2;
      px.x = walk_x;
      px.y = walk_y;
      px.red   = blend_channel(shade_from[LANE_RED], shade_to[LANE_RED], pix_index, pix_total);
      px.green = blend_channel(shade_from[LANE_GREEN], shade_to[LANE_GREEN], pix_index,
                               pix_total);
      px.blue  = blend_channel(shade_from[LANE_BLUE], shade_to[LANE_BLUE], pix_index, pix_total);
      px.in_image = (walk_x >= 0) && (walk_y >= 0) && (int'(walk_x) < int'(width_cfg)) &&
                    (int'(walk_y) < int'(height_cfg));
      px.last = (walk_x == goal_x) && (walk_y == goal_y);
      if (px.last) begin
         line_busy = 1'b0;
      end else begin
         // Both tests use the error term as it stood before this step.
         e2 = 2 * walk_err;
         if (e2 > -span_y_c) begin
            walk_err -= span_y_c;
            walk_x = x_neg ? walk_x - 1'b1 : walk_x + 1'b1;
         end
         if (e2 < span_x_c) begin
            walk_err += span_x_c;
            walk_y = y_neg ? walk_y - 1'b1 : walk_y + 1'b1;
         end
         pix_index++;
      end
      return px;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // Prediction runs before the result check so that the order within an edge cannot matter.
   always @(posedge clock) begin : track
      pixel_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_command == CMD_START)
               load_line(req_x_start, req_y_start, req_x_end, req_y_end,
                         req_red_start, req_green_start, req_blue_start,
                         req_red_end, req_green_end, req_blue_end);
            else if (line_busy)
               pixel_q.insert(pixel_q.size(), next_pixel());
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $error("pixel with no expectation at x %0d, y %0d", rsp_pixel_x, rsp_pixel_y);
               err_count++;
            end else begin
               want = pixel_q.pop_front();
               check_field("pixel_x", want.x, rsp_pixel_x);
               check_field("pixel_y", want.y, rsp_pixel_y);
               check_field("red", want.red, rsp_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
               check_field("in_image", want.in_image, rsp_in_image);
               check_field("last", want.last, rsp_last);
            end
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   initial begin : receiver
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_long) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp_long = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   function automatic int clamp_coord(input int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // A coordinate close to zero, close to the image edge, or anywhere at all.
   function automatic int near_edge(input int limit);
      int base;
      case ($urandom_range(2))
         0: base = 0;
         1: base = limit;
         default: base = rand_coord();
      endcase
      return clamp_coord(base + int'($urandom_range(40)) - 20);
   endfunction

   // Entered and left at a falling edge; valid stays high when the next transfer follows at once.
   task automatic send_req(input cmd_type cmd, input int x0, y0, x1, y1,
                           input logic [23:0] c0, c1);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command = cmd;
      req_x_start = COORD_BITS'(x0);
      req_y_start = COORD_BITS'(y0);
      req_x_end   = COORD_BITS'(x1);
      req_y_end   = COORD_BITS'(y1);
      {req_red_start, req_green_start, req_blue_start} = c0;
      {req_red_end, req_green_end, req_blue_end} = c1;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      @(negedge clock);
   endtask

   // Tick fields carry random junk, which the block must ignore.
   task automatic send_tick();
      send_req(CMD_TICK, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
               24'($urandom), 24'($urandom));
   endtask

   task automatic draw_line(input int x0, y0, x1, y1, input logic [23:0] c0, c1,
                            input int ticks);
      send_req(CMD_START, x0, y0, x1, y1, c0, c1);
      repeat (ticks) send_tick();
   endtask

   task automatic random_line();
      int x0, y0, x1, y1, steps, ticks, roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         // Endpoints anywhere; such a line is normally abandoned after a few pixels.
         x0 = rand_coord();
         y0 = rand_coord();
         x1 = rand_coord();
         y1 = rand_coord();
         ticks = $urandom_range(4, 1);
      end else begin
         x0 = near_edge(int'(width_cfg));
         y0 = near_edge(int'(height_cfg));
         x1 = clamp_coord(x0 + int'($urandom_range(24)) - 12);
         y1 = clamp_coord(y0 + int'($urandom_range(24)) - 12);
         steps = (x1 > x0) ? x1 - x0 : x0 - x1;
         if (((y1 > y0) ? y1 - y0 : y0 - y1) > steps)
            steps = (y1 > y0) ? y1 - y0 : y0 - y1;
         ticks = steps + 1;
         roll = $urandom_range(99);
         if (roll < 15) ticks += $urandom_range(2, 1);
         else if (roll < 25) ticks = $urandom_range(steps);
      end
      draw_line(x0, y0, x1, y1, 24'($urandom), 24'($urandom), ticks);
   endtask

   task automatic drain_pixels();
      req_valid = 1'b0;
      while (pixel_q.size() != 0) @(negedge clock);
   endtask

   // Brings the block to rest: all pixels out, no line loaded, and nothing left in its queue.
   task automatic quiesce();
      drain_pixels();
      if (line_busy) begin
         draw_line(0, 0, 0, 0, 24'h0, 24'h0, 1);
         drain_pixels();
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_index = idx;
      csr_data  = DIM_BITS'(value);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WIDTH) width_cfg = csr_data;
      else height_cfg = csr_data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_image(input int w, input int h);
      quiesce();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
   endtask

   task automatic test_idle_tick();
      send_tick();
      send_tick();
   endtask

   task automatic test_zero_length();
      draw_line(5, 7, 5, 7, 24'hff00ff, 24'h00ff00, 2);
      draw_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 24'hffffff, 24'h000000, 1);
   endtask

   task automatic test_start_while_busy();
      draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h000000, 24'hffffff, 3);
      draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'hffffff, 24'h000000, 2);
   endtask

   // Crosses the right-hand edge and the top edge of the image at its reset size.
   task automatic test_image_bounds();
      draw_line(1021, -2, 1025, 2, 24'h10e040, 24'hf00380, 5);
   endtask

   task automatic test_random_lines(input int count);
      int target;
      target = sent_items + count;
      while (sent_items < target) random_line();
   endtask

   task automatic test_size_settings();
      set_image(1, 1);
      test_random_lines(150);
      set_image(4096, 4096);
      test_random_lines(200);
      set_image(0, 0);
      test_random_lines(100);
      set_image((1 << DIM_BITS) - 1, (1 << DIM_BITS) - 1);
      test_random_lines(100);
      set_image($urandom_range(4096, 1), $urandom_range(4096, 1));
      idle_on = 1'b0;
      test_random_lines(150);
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_rsp_long = 1'b1;
      test_random_lines(80);
      idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      test_random_lines(30);
      drain_pixels();
      test_random_lines(30);
   endtask

   initial begin : main
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_START;
      req_x_start     = '0;
      req_y_start     = '0;
      req_x_end       = '0;
      req_y_end       = '0;
      req_red_start   = '0;
      req_green_start = '0;
      req_blue_start  = '0;
      req_red_end     = '0;
      req_green_end   = '0;
      req_blue_end    = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_WIDTH;
      csr_data        = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_tick();
      test_zero_length();
      test_start_while_busy();
      test_image_bounds();
      test_random_lines(400);
      test_size_settings();
      test_backpressure();
      test_sender_pause();

      drain_pixels();
      repeat (SETTLE) @(negedge clock);
      if (err_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
